FILE: hw/rtl/dstp_pkg.sv
// shared types and constants for the dual sensor throttle position block
`default_nettype none

package dstp_pkg;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned SPAN_A_W = 7;
    localparam int unsigned SPAN_B_W = 8;
    localparam int unsigned SHARE_W  = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned PROD_W   = 18;

    // register index codes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_B  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_B = 3'd5;

    // reset values
    localparam logic [SAMPLE_W-1:0] RST_LOW_A  = 10'd0;
    localparam logic [SAMPLE_W-1:0] RST_HIGH_A = 10'd1013;
    localparam logic [SAMPLE_W-1:0] RST_LOW_B  = 10'd148;
    localparam logic [SAMPLE_W-1:0] RST_HIGH_B = 10'd864;
    localparam logic [SPAN_A_W-1:0] RST_SPAN_A = 7'd127;
    localparam logic [SPAN_B_W-1:0] RST_SPAN_B = 8'd128;

    localparam logic [SHARE_W-1:0] FULL_SCALE = 8'd255;

    typedef struct packed {
        logic [SAMPLE_W-1:0] low_a;
        logic [SAMPLE_W-1:0] high_a;
        logic [SAMPLE_W-1:0] low_b;
        logic [SAMPLE_W-1:0] high_b;
        logic [SPAN_A_W-1:0] span_a;
        logic [SPAN_B_W-1:0] span_b;
    } t_cfg;

    // one classified item handed from front to back
    typedef struct packed {
        logic                kept;
        logic                mux_sel;
        logic [SAMPLE_W-1:0] stored_a;
        logic [SAMPLE_W-1:0] stored_b;
        logic [SAMPLE_W-1:0] reg_lim;
    } t_entry;

    typedef struct packed {
        logic                kept;
        logic                mux_sel;
        logic [SAMPLE_W-1:0] reading_a;
        logic [SAMPLE_W-1:0] reading_b;
        logic [SHARE_W-1:0]  position;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/dstp_front.sv
// front end: phase tracking, clamping and storage of sensor readings
`default_nettype none

module dstp_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_full,
    input  wire logic [dstp_pkg::SAMPLE_W-1:0] i_adc_sample,
    input  wire logic [dstp_pkg::SAMPLE_W-1:0] i_regulator_position,
    input  wire dstp_pkg::t_cfg                i_cfg,
    output logic                               o_in_ready,
    output logic                               o_push,
    output dstp_pkg::t_entry                   o_entry
);
    import dstp_pkg::*;

    localparam logic [1:0] PH_KEEP_B = 2'd0;
    localparam logic [1:0] PH_KEEP_A = 2'd2;

    function automatic logic [SAMPLE_W-1:0] clamp_win(
        input logic [SAMPLE_W-1:0] v,
        input logic [SAMPLE_W-1:0] lo,
        input logic [SAMPLE_W-1:0] hi
    );
        logic [SAMPLE_W-1:0] t;
        t = (v < lo) ? lo : v;
        return (t > hi) ? hi : t;
    endfunction

    logic [1:0]          r_phase;
    logic [SAMPLE_W-1:0] r_stored_a;
    logic [SAMPLE_W-1:0] r_stored_b;
    logic                r_channel;
    logic [SAMPLE_W-1:0] n_stored_a;
    logic [SAMPLE_W-1:0] n_stored_b;
    logic                n_channel;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        n_stored_a = r_stored_a;
        n_stored_b = r_stored_b;
        n_channel  = r_channel;
        unique case (r_phase)
            PH_KEEP_B: begin
                n_stored_b = clamp_win(i_adc_sample, i_cfg.low_b, i_cfg.high_b);
                n_channel  = 1'b0;
            end
            PH_KEEP_A: begin
                n_stored_a = clamp_win(i_adc_sample, i_cfg.low_a, i_cfg.high_a);
                n_channel  = 1'b1;
            end
            default: begin
                // conversion right after a channel switch is thrown away
            end
        endcase
    end

    always_comb begin
        o_entry.kept     = !r_phase[0];
        o_entry.mux_sel  = n_channel;
        o_entry.stored_a = n_stored_a;
        o_entry.stored_b = n_stored_b;
        o_entry.reg_lim  = (i_regulator_position > n_stored_a) ? n_stored_a
                                                               : i_regulator_position;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_stored_a <= '0;
            r_stored_b <= RST_LOW_B;
            r_channel  <= 1'b0;
        end else if (o_push) begin
            r_phase    <= r_phase + 2'd1;
            r_stored_a <= n_stored_a;
            r_stored_b <= n_stored_b;
            r_channel  <= n_channel;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dstp_queue.sv
// small fifo between front and back
`default_nettype none

module dstp_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire dstp_pkg::t_entry i_entry,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output dstp_pkg::t_entry      o_head
);
    import dstp_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_entry        r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dstp_back.sv
// back end: share computation and rescale on one shared radix-4 divider
`default_nettype none

module dstp_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  wire dstp_pkg::t_entry i_head,
    input  wire dstp_pkg::t_cfg   i_cfg,
    input  wire logic             i_out_ready,
    output logic                  o_pop,
    output logic                  o_out_valid,
    output dstp_pkg::t_result     o_result
);
    import dstp_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [1:0] OP_SA  = 2'd0;
    localparam logic [1:0] OP_SB  = 2'd1;
    localparam logic [1:0] OP_RP  = 2'd2;
    localparam logic [1:0] OP_POS = 2'd3;

    localparam logic [1:0] LAST_STEP = 2'd3;

    logic [1:0]          r_state;
    logic [1:0]          r_op;
    logic [1:0]          r_step;
    logic                r_out_valid;

    logic [PROD_W-1:0]   r_rem;
    logic [SAMPLE_W-1:0] r_div;
    logic [SHARE_W-1:0]  r_quo;
    logic                r_sat;
    logic [SHARE_W-1:0]  r_sa;
    logic [SHARE_W-1:0]  r_sb;
    logic [SHARE_W-1:0]  r_rp;
    t_result             r_out;

    // share setup operands
    logic [SAMPLE_W-1:0] s_val;
    logic [SAMPLE_W-1:0] s_lo;
    logic [SAMPLE_W-1:0] s_hi;
    logic [SPAN_B_W-1:0] s_span;
    logic [SAMPLE_W-1:0] s_den;
    logic [SAMPLE_W-1:0] s_dif;
    logic [SAMPLE_W-1:0] s_d;
    logic                s_degen;
    logic [PROD_W-1:0]   s_prod;

    // rescale setup operands
    logic [SHARE_W:0]    p_sum;
    logic [SHARE_W:0]    p_num;
    logic [PROD_W-1:0]   p_prod;
    logic [SHARE_W-1:0]  p_den;
    logic                p_sat;

    // divider step
    logic [2:0]          hi_idx;
    logic [2:0]          lo_idx;
    logic [PROD_W-1:0]   d_hi;
    logic [PROD_W-1:0]   d_lo;
    logic                ge_hi;
    logic                ge_lo;
    logic [PROD_W-1:0]   rem_mid;
    logic [PROD_W-1:0]   n_rem;
    logic [SHARE_W-1:0]  n_quo;

    logic                out_free;

    always_comb begin
        unique case (r_op)
            OP_SA: begin
                s_val  = i_head.stored_a;
                s_lo   = i_cfg.low_a;
                s_hi   = i_cfg.high_a;
                s_span = {1'b0, i_cfg.span_a};
            end
            OP_SB: begin
                s_val  = i_head.stored_b;
                s_lo   = i_cfg.low_b;
                s_hi   = i_cfg.high_b;
                s_span = i_cfg.span_b;
            end
            OP_RP, OP_POS: begin
                s_val  = i_head.reg_lim;
                s_lo   = i_cfg.low_a;
                s_hi   = i_cfg.high_a;
                s_span = {1'b0, i_cfg.span_a};
            end
        endcase
    end

    assign s_degen = (s_hi <= s_lo);
    assign s_den   = s_hi - s_lo;
    assign s_dif   = (s_val > s_lo) ? (s_val - s_lo) : '0;
    assign s_d     = (s_dif > s_den) ? s_den : s_dif;
    assign s_prod  = {8'b0, s_d} * {10'b0, s_span};

    assign p_sum  = {1'b0, r_sa} + {1'b0, r_sb};
    assign p_num  = (p_sum > {1'b0, r_rp}) ? (p_sum - {1'b0, r_rp}) : '0;
    // num * 255 as num * 256 - num
    assign p_prod = {1'b0, p_num, 8'b0} - {9'b0, p_num};
    assign p_den  = FULL_SCALE - r_rp;
    assign p_sat  = (p_prod >= {2'b0, p_den, 8'b0});

    // two quotient bits per cycle, high to low
    assign hi_idx  = {~r_step, 1'b1};
    assign lo_idx  = {~r_step, 1'b0};
    assign d_hi    = {8'b0, r_div} << hi_idx;
    assign ge_hi   = (r_rem >= d_hi);
    assign rem_mid = ge_hi ? (r_rem - d_hi) : r_rem;
    assign d_lo    = {8'b0, r_div} << lo_idx;
    assign ge_lo   = (rem_mid >= d_lo);
    assign n_rem   = ge_lo ? (rem_mid - d_lo) : rem_mid;
    assign n_quo   = {r_quo[SHARE_W-3:0], ge_hi, ge_lo};

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_pop       = (r_state == ST_DONE) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_SA;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= ST_SETUP;
                        r_op    <= OP_SA;
                    end
                end
                ST_SETUP: begin
                    r_state <= ST_DIV;
                    r_step  <= '0;
                end
                ST_DIV: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == LAST_STEP) begin
                        if (r_op == OP_POS) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_op    <= r_op + 2'd1;
                            r_state <= ST_SETUP;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase

            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_SETUP: begin
                r_quo <= '0;
                if (r_op == OP_POS) begin
                    r_rem <= p_prod;
                    r_div <= {2'b0, p_den};
                    r_sat <= p_sat;
                end else begin
                    r_rem <= s_degen ? '0 : s_prod;
                    r_div <= s_degen ? SAMPLE_W'(1) : s_den;
                    r_sat <= 1'b0;
                end
            end
            ST_DIV: begin
                r_rem <= n_rem;
                // saturated position replaces the last quotient
                r_quo <= (r_step == LAST_STEP && r_op == OP_POS && r_sat) ? FULL_SCALE
                                                                          : n_quo;
                if (r_step == LAST_STEP) begin
                    unique case (r_op)
                        OP_SA:  r_sa <= n_quo;
                        OP_SB:  r_sb <= n_quo;
                        OP_RP:  r_rp <= n_quo;
                        OP_POS: begin
                            // position stays in the quotient register
                        end
                    endcase
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out.kept      <= i_head.kept;
                    r_out.mux_sel   <= i_head.mux_sel;
                    r_out.reading_a <= i_head.stored_a;
                    r_out.reading_b <= i_head.stored_b;
                    r_out.position  <= r_quo;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dual_sensor_throttle_position_top.sv
// top level of the dual sensor throttle position block
// the back end takes one item at a time: idle, then setup and divide steps for each of four divisions, then done
// the front end keeps accepting until the queue is full, so input transfers can burst
// reset: synchronous active low; config registers return to their defaults,
// stored readings to zero and the second sensor's default low bound, queue empties
`default_nettype none

module dual_sensor_throttle_position_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [dstp_pkg::SAMPLE_W-1:0]    i_adc_sample,
    input  wire logic [dstp_pkg::SAMPLE_W-1:0]    i_regulator_position,
    // output channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_sample_kept,
    output logic                                  o_mux_select,
    output logic [dstp_pkg::SAMPLE_W-1:0]         o_reading_a,
    output logic [dstp_pkg::SAMPLE_W-1:0]         o_reading_b,
    output logic [dstp_pkg::SHARE_W-1:0]          o_throttle_position,
    // configuration writes
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [dstp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [dstp_pkg::SAMPLE_W-1:0]    i_cfg_data
);
    import dstp_pkg::*;

    t_cfg    r_cfg;
    t_entry  front_entry;
    t_entry  head_entry;
    t_result back_result;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_empty;

    // config registers; the user must write them only while the block is idle, the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_a  <= RST_LOW_A;
            r_cfg.high_a <= RST_HIGH_A;
            r_cfg.low_b  <= RST_LOW_B;
            r_cfg.high_b <= RST_HIGH_B;
            r_cfg.span_a <= RST_SPAN_A;
            r_cfg.span_b <= RST_SPAN_B;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_LOW_A:  r_cfg.low_a  <= i_cfg_data;
                CFG_HIGH_A: r_cfg.high_a <= i_cfg_data;
                CFG_LOW_B:  r_cfg.low_b  <= i_cfg_data;
                CFG_HIGH_B: r_cfg.high_b <= i_cfg_data;
                CFG_SPAN_A: r_cfg.span_a <= i_cfg_data[SPAN_A_W-1:0];
                CFG_SPAN_B: r_cfg.span_b <= i_cfg_data[SPAN_B_W-1:0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // front: phase counter, clamp and sensor storage, one item per transfer
    dstp_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_full               (q_full),
        .i_adc_sample         (i_adc_sample),
        .i_regulator_position (i_regulator_position),
        .i_cfg                (r_cfg),
        .o_in_ready           (o_in_ready),
        .o_push               (push),
        .o_entry              (front_entry)
    );

    // decouples front from the multi-cycle back end
    dstp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_entry)
    );

    // back: three interpolated shares and the rescale, then the output register
    dstp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (head_entry),
        .i_cfg       (r_cfg),
        .i_out_ready (i_out_ready),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_result    (back_result)
    );

    assign o_sample_kept       = back_result.kept;
    assign o_mux_select        = back_result.mux_sel;
    assign o_reading_a         = back_result.reading_a;
    assign o_reading_b         = back_result.reading_b;
    assign o_throttle_position = back_result.position;

endmodule

`default_nettype wire

FILE: hw/rtl/dstp_checker.sv
// port-level checks for the dual sensor throttle position block, with bind
`default_nettype none

module dstp_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_ready,
    input wire logic                             o_sample_kept,
    input wire logic                             o_mux_select,
    input wire logic [dstp_pkg::SAMPLE_W-1:0]    o_reading_a,
    input wire logic [dstp_pkg::SAMPLE_W-1:0]    o_reading_b,
    input wire logic [dstp_pkg::SHARE_W-1:0]     o_throttle_position
);
    import dstp_pkg::*;

    logic                out_xfer;
    logic [1:0]          r_xfer_cnt;
    logic [SAMPLE_W-1:0] r_prev_a;
    logic [SAMPLE_W-1:0] r_prev_b;

    assign out_xfer = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xfer_cnt <= '0;
            r_prev_a   <= '0;
            r_prev_b   <= RST_LOW_B;
        end else if (out_xfer) begin
            r_xfer_cnt <= r_xfer_cnt + 2'd1;
            r_prev_a   <= o_reading_a;
            r_prev_b   <= o_reading_b;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_throttle_position)
            && $stable(o_reading_a) && $stable(o_reading_b))
        else $error("stalled output changed");

    a_kept_alternates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> (o_sample_kept == !r_xfer_cnt[0]))
        else $error("kept flag out of sequence");

    a_mux_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_sample_kept |-> (o_mux_select == r_xfer_cnt[1]))
        else $error("channel select out of sequence");

    a_discard_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && !o_sample_kept |->
            (o_reading_a == r_prev_a) && (o_reading_b == r_prev_b))
        else $error("discarded sample changed a reading");

endmodule

bind dual_sensor_throttle_position_top dstp_checker u_dstp_checker (.*);

`default_nettype wire

FILE: sim/tb_dual_sensor_throttle_position_top.sv
// testbench for the dual sensor throttle position block: random and directed checking
`timescale 1ns / 1ps

import dstp_pkg::*;

// predicts every result of the block and holds the readings still owed by it
class throttle_scoreboard;

    t_cfg             cfg;
    logic [1:0]       phase;
    logic [SAMPLE_W-1:0] stored_a;
    logic [SAMPLE_W-1:0] stored_b;
    logic             channel;
    t_result          expected_readings[$];
    int unsigned      mismatches;

    function new();
        cfg.low_a  = RST_LOW_A;
        cfg.high_a = RST_HIGH_A;
        cfg.low_b  = RST_LOW_B;
        cfg.high_b = RST_HIGH_B;
        cfg.span_a = RST_SPAN_A;
        cfg.span_b = RST_SPAN_B;
        phase      = 2'd0;
        stored_a   = '0;
        stored_b   = RST_LOW_B;
        channel    = 1'b0;
        mismatches = 0;
    endfunction

    function void report_mismatch(string msg);
        if (mismatches < 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endfunction

    function int pending();
        return expected_readings.size();
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
        case (idx)
            CFG_LOW_A:  cfg.low_a  = data;
            CFG_HIGH_A: cfg.high_a = data;
            CFG_LOW_B:  cfg.low_b  = data;
            CFG_HIGH_B: cfg.high_b = data;
            CFG_SPAN_A: cfg.span_a = data[SPAN_A_W-1:0];
            CFG_SPAN_B: cfg.span_b = data[SPAN_B_W-1:0];
            default: ;
        endcase
    endfunction

    function logic [SAMPLE_W-1:0] clamp_window(logic [SAMPLE_W-1:0] v,
                                                logic [SAMPLE_W-1:0] lo,
                                                logic [SAMPLE_W-1:0] hi);
        logic [SAMPLE_W-1:0] c;
        c = (v < lo) ? lo : v;
        return (c > hi) ? hi : c;
    endfunction

    // interpolated share, offset saturated into the window, zero for an empty or inverted window
    function int unsigned window_share(int unsigned v, int unsigned lo, int unsigned hi,
                                       int unsigned span);
        int unsigned width;
        int unsigned d;
        if (hi <= lo)
            return 0;
        width = hi - lo;
        d = (v > lo) ? v - lo : 0;
        if (d > width)
            d = width;
        return (span * d) / width;
    endfunction

    function void note_conversion(logic [SAMPLE_W-1:0] sample,
                                  logic [SAMPLE_W-1:0] reg_pos);
        t_result     r;
        logic [SAMPLE_W-1:0] reg_lim;
        int unsigned share_a;
        int unsigned share_b;
        int unsigned share_reg;
        int unsigned num;
        int unsigned den;
        int unsigned pos;
        r.kept = ~phase[0];
        if (!phase[0]) begin
            if (phase == 2'd2) begin
                stored_a = clamp_window(sample, cfg.low_a, cfg.high_a);
                channel  = 1'b1;
            end else begin
                stored_b = clamp_window(sample, cfg.low_b, cfg.high_b);
                channel  = 1'b0;
            end
        end
        phase = phase + 2'd1;

        share_a   = window_share(stored_a, cfg.low_a, cfg.high_a, cfg.span_a);
        share_b   = window_share(stored_b, cfg.low_b, cfg.high_b, cfg.span_b);
        reg_lim   = (reg_pos > stored_a) ? stored_a : reg_pos;
        share_reg = window_share(reg_lim, cfg.low_a, cfg.high_a, cfg.span_a);

        num = share_a + share_b;
        num = (num > share_reg) ? num - share_reg : 0;
        den = FULL_SCALE - share_reg;
        pos = (num * FULL_SCALE) / den;
        if (pos > FULL_SCALE)
            pos = FULL_SCALE;

        r.mux_sel   = channel;
        r.reading_a = stored_a;
        r.reading_b = stored_b;
        r.position  = pos[SHARE_W-1:0];
        expected_readings.push_back(r);
    endfunction

    function void check_reading(t_result seen);
        t_result e;
        if (expected_readings.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", seen));
            return;
        end
        e = expected_readings.pop_front();
        if (seen.kept !== e.kept)
            report_mismatch($sformatf("sample_kept %b, want %b", seen.kept, e.kept));
        if (seen.mux_sel !== e.mux_sel)
            report_mismatch($sformatf("mux_select %b, want %b", seen.mux_sel, e.mux_sel));
        if (seen.reading_a !== e.reading_a)
            report_mismatch($sformatf("reading_a %0d, want %0d",
                                      seen.reading_a, e.reading_a));
        if (seen.reading_b !== e.reading_b)
            report_mismatch($sformatf("reading_b %0d, want %0d",
                                      seen.reading_b, e.reading_b));
        if (seen.position !== e.position)
            report_mismatch($sformatf("throttle_position %0d, want %0d",
                                      seen.position, e.position));
    endfunction

endclass

module tb_dual_sensor_throttle_position_top;

    // index codes with no register behind them, written to show they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    localparam int LATENCY     = 22;
    localparam int STALL_LIMIT = 4000;
    localparam int IDLE_PCT    = 12;

    // directed conversions: windows edges, clamping from both sides, regulator above reading
    localparam logic [SAMPLE_W-1:0] DIRECTED_SAMPLE [20] = '{
        10'd0,   10'd1023, 10'd1023, 10'd0,   10'd1023, 10'd512, 10'd0,    10'd1023,
        10'd500, 10'd5,    10'd700,  10'd3,   10'd148,  10'd9,   10'd1013, 10'd1,
        10'd864, 10'd0,    10'd1012, 10'd0
    };
    localparam logic [SAMPLE_W-1:0] DIRECTED_REG [20] = '{
        10'd0,   10'd1023, 10'd1023, 10'd0,   10'd0,    10'd512, 10'd0,    10'd1023,
        10'd1023, 10'd5,   10'd300,  10'd3,   10'd700,  10'd9,   10'd1013, 10'd1,
        10'd0,   10'd0,    10'd1022, 10'd0
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [SAMPLE_W-1:0]     i_adc_sample = '0;
    logic [SAMPLE_W-1:0]     i_regulator_position = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic                    o_sample_kept;
    logic                    o_mux_select;
    logic [SAMPLE_W-1:0]     o_reading_a;
    logic [SAMPLE_W-1:0]     o_reading_b;
    logic [SHARE_W-1:0]      o_throttle_position;
    logic                    i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [SAMPLE_W-1:0]     i_cfg_data = '0;

    // while set, neither side idles
    logic                    quiet_stretch = 1'b0;
    int                      stall_cycles = 0;

    throttle_scoreboard sb = new();

    dual_sensor_throttle_position_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_adc_sample         (i_adc_sample),
        .i_regulator_position (i_regulator_position),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_sample_kept        (o_sample_kept),
        .o_mux_select         (o_mux_select),
        .o_reading_a          (o_reading_a),
        .o_reading_b          (o_reading_b),
        .o_throttle_position  (o_throttle_position),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // receiver back-pressure, off during the quiet stretch
    always @(posedge i_clk) begin
        i_out_ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
    end

    // result monitor: every output transfer is checked against the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_result seen;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.kept      = o_sample_kept;
            seen.mux_sel   = o_mux_select;
            seen.reading_a = o_reading_a;
            seen.reading_b = o_reading_b;
            seen.position  = o_throttle_position;
            sb.check_reading(seen);
        end
    end

    // watchdog: ends the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL dual_sensor_throttle_position_top");
            $finish;
        end
    end

    // one conversion transfer, with random idle cycles ahead of it
    task automatic send_conversion(input logic [SAMPLE_W-1:0] sample,
                                   input logic [SAMPLE_W-1:0] reg_pos);
        while (!quiet_stretch && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_adc_sample         <= sample;
        i_regulator_position <= reg_pos;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        // transfer took place at this edge
        sb.note_conversion(sample, reg_pos);
    endtask

    // drain every owed result, then let the pipeline run dry
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SAMPLE_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.apply_register(idx, data);
    endtask

    // full register set; only called with the block idle
    task automatic program_windows(input logic [SAMPLE_W-1:0] low_a, high_a, low_b, high_b,
                                   input logic [SAMPLE_W-1:0] span_a, span_b);
        settle();
        write_register(CFG_LOW_A, low_a);
        write_register(CFG_HIGH_A, high_a);
        write_register(CFG_LOW_B, low_b);
        write_register(CFG_HIGH_B, high_b);
        write_register(CFG_SPAN_A, span_a);
        write_register(CFG_SPAN_B, span_b);
        write_register($urandom_range(1) ? CFG_UNUSED_HI : CFG_UNUSED_LO,
                       SAMPLE_W'($urandom_range(1023)));
        i_cfg_wr_en <= 1'b0;
    endtask

    // a conversion value, biased toward the current window edges and the rails
    function automatic logic [SAMPLE_W-1:0] pick_value();
        logic [SAMPLE_W-1:0] edge_val;
        if ($urandom_range(99) >= 30)
            return SAMPLE_W'($urandom_range(1023));
        case ($urandom_range(5))
            0: edge_val = sb.cfg.low_a;
            1: edge_val = sb.cfg.high_a;
            2: edge_val = sb.cfg.low_b;
            3: edge_val = sb.cfg.high_b;
            4: edge_val = '0;
            default: edge_val = '1;
        endcase
        // step just past the edge now and then
        case ($urandom_range(3))
            0: edge_val = edge_val + 1'b1;
            1: edge_val = edge_val - 1'b1;
            default: ;
        endcase
        return edge_val;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
            send_conversion(pick_value(), pick_value());
    endtask

    initial begin : stimulus
        logic [SAMPLE_W-1:0] lo_a;
        logic [SAMPLE_W-1:0] lo_b;
        logic [SAMPLE_W-1:0] hi_a;
        logic [SAMPLE_W-1:0] hi_b;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset windows: directed edges, then random traffic
        for (int n = 0; n < 20; n++)
            send_conversion(DIRECTED_SAMPLE[n], DIRECTED_REG[n]);
        run_random(280);

        // widest windows and an oversized second span, with no idling at all
        quiet_stretch <= 1'b1;
        program_windows(10'd0, 10'd1023, 10'd0, 10'd1023, 10'd127, 10'd255);
        run_random(300);
        quiet_stretch <= 1'b0;

        // empty first window and inverted second window, both shares drop to zero
        program_windows(10'd500, 10'd500, 10'd800, 10'd200, 10'd127, 10'd128);
        run_random(200);

        // one-step windows at both rails, smallest spans
        program_windows(10'd1022, 10'd1023, 10'd0, 10'd1, 10'd1, 10'd1);
        run_random(200);

        // span data with bits above the register width
        program_windows(10'd100, 10'd900, 10'd50, 10'd950, 10'h380, 10'h3ff);
        run_random(100);

        // random settings, now and then an inverted or empty window
        for (int k = 0; k < 6; k++) begin
            lo_a = SAMPLE_W'($urandom_range(1022));
            lo_b = SAMPLE_W'($urandom_range(1022));
            hi_a = ($urandom_range(3) == 0) ? SAMPLE_W'($urandom_range(1023))
                                            : SAMPLE_W'($urandom_range(1023, lo_a + 1));
            hi_b = ($urandom_range(3) == 0) ? SAMPLE_W'($urandom_range(1023))
                                            : SAMPLE_W'($urandom_range(1023, lo_b + 1));
            program_windows(lo_a, hi_a, lo_b, hi_b, SAMPLE_W'($urandom_range(1023)),
                            SAMPLE_W'($urandom_range(1023)));
            run_random(150);
        end

        settle();
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("PASS dual_sensor_throttle_position_top");
        else
            $display("FAIL dual_sensor_throttle_position_top");
        $finish;
    end

endmodule
